// ----- hw/rtl/button_mode_controller_macros.svh -----
// Assertion macros for the button mode controller RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef BUTTON_MODE_CONTROLLER_MACROS_SVH
`define BUTTON_MODE_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BMC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMC_ASSERT_IMPL(label, ante, cons, msg)
`define BMC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/bmc_pkg.sv -----
// Shared types, mode codes and color lookup for the button mode controller.
// No dependencies.
package bmc_pkg;

  localparam logic [2:0] MD_OFF   = 3'd0;
  localparam logic [2:0] MD_STD   = 3'd1;
  localparam logic [2:0] MD_CFG   = 3'd2;
  localparam logic [2:0] MD_MAINT = 3'd3;
  localparam logic [2:0] MD_ECO   = 3'd4;

  localparam logic [1:0] REG_HOLD_MS        = 2'd0;
  localparam logic [1:0] REG_LOG_INTERVAL   = 2'd1;
  localparam logic [1:0] REG_CONFIG_TIMEOUT = 2'd2;

  localparam logic [15:0] HOLD_MS_RST        = 16'd5000;
  localparam logic [15:0] LOG_INTERVAL_RST   = 16'd10;
  localparam logic [15:0] CONFIG_TIMEOUT_RST = 16'd180;
  localparam logic [15:0] HOLD_MAX           = 16'hFFFF;

  localparam int Q_DEPTH = 3;

  typedef struct packed {
    logic second_tick;
    logic green_pressed;
    logic red_pressed;
  } item_t;

  typedef struct packed {
    logic [7:0] led_blue;
    logic [7:0] led_green;
    logic [7:0] led_red;
    logic       acquire;
    logic       mode_changed;
    logic [2:0] mode_now;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  function automatic color_t mode_color(input logic [2:0] mode);
    color_t c;
    case (mode)
      MD_STD:   c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      MD_CFG:   c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      MD_MAINT: c = '{r: 8'd255, g: 8'd80,  b: 8'd0};
      MD_ECO:   c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      default:  c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/button_mode_controller.sv -----
// Button mode controller: an accepted input transaction is loaded into the input
// register, then the mode logic writes its result into a 3-entry result queue,
// which drives out_tvalid; one transaction per cycle while in_tready is high.
// in_tready drops only when the queue and the input register hold three results.
// Synchronous active-low reset: mode off, prior mode standard, counters and flags
// cleared, registers at 5000 ms / 10 s / 180 s, queue empty.
`include "button_mode_controller_macros.svh"

module button_mode_controller import bmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] red_pressed, [1] green_pressed, [2] second_tick
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] mode_now, [3] mode_changed, [4] acquire,
                                  // [12:5] led_red, [20:13] led_green, [28:21] led_blue
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers; index 3 is ignored.
  logic [15:0] hold_ms_r, log_interval_r, config_timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ms_r        <= HOLD_MS_RST;
      log_interval_r   <= LOG_INTERVAL_RST;
      config_timeout_r <= CONFIG_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_MS:        hold_ms_r        <= cfg_data;
        REG_LOG_INTERVAL:   log_interval_r   <= cfg_data;
        REG_CONFIG_TIMEOUT: config_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. It always drains into the queue the next cycle, so the
  // queue only needs a free slot reserved for what sits here.
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    in_accept;
  q_stat_t q_stat;
  logic [2:0] occupancy;

  assign occupancy = {1'b0, q_stat.count} + {2'b0, s1_valid_r};
  assign in_tready = (occupancy < 3'(Q_DEPTH));
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_item_r <= item_t'(in_tdata[2:0]);
  end

  // Long-press detectors, one per button.
  logic red_fire, green_fire;

  bmc_press_detect u_red_press (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_valid_r),
    .level   (s1_item_r.red_pressed),
    .hold_ms (hold_ms_r),
    .fire    (red_fire)
  );

  bmc_press_detect u_green_press (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_valid_r),
    .level   (s1_item_r.green_pressed),
    .hold_ms (hold_ms_r),
    .fire    (green_fire)
  );

  // Mode state machine and timers.
  res_t core_res;

  bmc_mode_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (s1_valid_r),
    .item             (s1_item_r),
    .red_fire         (red_fire),
    .green_fire       (green_fire),
    .log_interval_s   (log_interval_r),
    .config_timeout_s (config_timeout_r),
    .res              (core_res)
  );

  // Result queue feeding the output stream.
  res_t q_data;

  bmc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (core_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data),
    .stat      (q_stat)
  );

  assign out_tdata = {3'b000, q_data};

  // Checks
  `BMC_ASSERT_IMPL(a_no_overflow, 1'b1, occupancy <= 3'(Q_DEPTH), "result queue overflow")
  `BMC_ASSERT_NEXT(a_accept_loads, in_accept, s1_valid_r, "accepted transaction not registered")
  `BMC_ASSERT_IMPL(a_acq_mode, s1_valid_r && core_res.acquire, core_res.mode_now != MD_CFG && core_res.mode_now != MD_OFF, "acquire raised in config or off mode")

endmodule

// ----- hw/rtl/bmc_press_detect.sv -----
// Long-press detector for one button: saturating hold counter, tracking and fired bits.
// Depends on bmc_pkg.
module bmc_press_detect import bmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,        // one item processed this cycle
  input  logic        level,
  input  logic [15:0] hold_ms,
  output logic        fire
);

  logic [15:0] count_r, count_nxt;
  logic        tracking_r, tracking_nxt;
  logic        fired_r, fired_nxt;

  always_comb begin
    count_nxt    = 16'd0;
    tracking_nxt = 1'b0;
    fired_nxt    = 1'b0;
    fire         = 1'b0;
    if (en && level) begin
      tracking_nxt = 1'b1;
      if (!tracking_r) begin
        count_nxt = 16'd0;
      end else if (count_r != HOLD_MAX) begin
        count_nxt = count_r + 16'd1;
      end else begin
        count_nxt = count_r;
      end
      fire      = !fired_r && (count_nxt > hold_ms);
      fired_nxt = fired_r || fire;
    end else if (!en) begin
      count_nxt    = count_r;
      tracking_nxt = tracking_r;
      fired_nxt    = fired_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= 16'd0;
      tracking_r <= 1'b0;
      fired_r    <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      tracking_r <= tracking_nxt;
      fired_r    <= fired_nxt;
    end
  end

endmodule

// ----- hw/rtl/bmc_mode_core.sv -----
// Mode state, second timers and pending flags; builds one result per processed item.
// Depends on bmc_pkg; button fire flags come from bmc_press_detect.
module bmc_mode_core import bmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  item_t       item,
  input  logic        red_fire,
  input  logic        green_fire,
  input  logic [15:0] log_interval_s,
  input  logic [15:0] config_timeout_s,
  output res_t        res
);

  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  prior_r, prior_nxt;
  logic [15:0] cfg_sec_r, cfg_sec_nxt;
  logic [16:0] data_sec_r, data_sec_nxt;
  logic        ret_pend_r, ret_pend_nxt;
  logic        acq_pend_r, acq_pend_nxt;

  logic        changed;
  logic        acq;
  logic [16:0] wait_s;
  logic        slow;
  color_t      col;

  assign slow   = (mode_r == MD_ECO) || (mode_r == MD_MAINT && prior_r == MD_ECO);
  assign wait_s = slow ? {log_interval_s, 1'b0} : {1'b0, log_interval_s};

  always_comb begin
    mode_nxt     = mode_r;
    prior_nxt    = prior_r;
    cfg_sec_nxt  = cfg_sec_r;
    data_sec_nxt = data_sec_r;
    ret_pend_nxt = ret_pend_r;
    acq_pend_nxt = acq_pend_r;
    changed      = 1'b0;
    acq          = 1'b0;

    // second tick first
    if (item.second_tick && mode_r != MD_OFF) begin
      if (mode_r == MD_CFG) begin
        cfg_sec_nxt = cfg_sec_r + 16'd1;
        if (cfg_sec_nxt >= config_timeout_s) begin
          cfg_sec_nxt  = 16'd0;
          ret_pend_nxt = 1'b1;
        end
      end else begin
        data_sec_nxt = data_sec_r + 17'd1;
        if (data_sec_nxt >= wait_s) begin
          data_sec_nxt = 17'd0;
          acq_pend_nxt = 1'b1;
        end
      end
    end

    if (red_fire) begin
      if (mode_nxt == MD_MAINT) begin
        mode_nxt = prior_r;
      end else begin
        prior_nxt = mode_nxt;
        mode_nxt  = MD_MAINT;
      end
      changed = 1'b1;
    end

    if (green_fire) begin
      if (mode_nxt == MD_ECO) begin
        mode_nxt = MD_STD;
        changed  = 1'b1;
      end else if (mode_nxt == MD_STD) begin
        mode_nxt = MD_ECO;
        changed  = 1'b1;
      end
    end

    if (mode_nxt == MD_OFF) begin
      if (item.red_pressed) begin
        mode_nxt = MD_CFG;
        changed  = 1'b1;
      end else if (item.green_pressed) begin
        mode_nxt = MD_STD;
        changed  = 1'b1;
      end
    end else begin
      if (mode_nxt == MD_CFG && ret_pend_nxt) begin
        ret_pend_nxt = 1'b0;
        mode_nxt     = MD_STD;
        changed      = 1'b1;
      end
      if (acq_pend_nxt && mode_nxt != MD_CFG) begin
        acq_pend_nxt = 1'b0;
        acq          = 1'b1;
      end
    end

    // every mode set restarts both second counters
    if (changed) begin
      cfg_sec_nxt  = 16'd0;
      data_sec_nxt = 17'd0;
    end
  end

  assign col = mode_color(mode_nxt);

  always_comb begin
    res.mode_now     = mode_nxt;
    res.mode_changed = changed;
    res.acquire      = acq;
    res.led_red      = col.r;
    res.led_green    = col.g;
    res.led_blue     = col.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MD_OFF;
      prior_r    <= MD_STD;
      cfg_sec_r  <= 16'd0;
      data_sec_r <= 17'd0;
      ret_pend_r <= 1'b0;
      acq_pend_r <= 1'b0;
    end else if (en) begin
      mode_r     <= mode_nxt;
      prior_r    <= prior_nxt;
      cfg_sec_r  <= cfg_sec_nxt;
      data_sec_r <= data_sec_nxt;
      ret_pend_r <= ret_pend_nxt;
      acq_pend_r <= acq_pend_nxt;
    end
  end

endmodule

// ----- hw/rtl/bmc_out_queue.sv -----
// Three-entry result queue that decouples the result channel from processing.
// Depends on bmc_pkg.
module bmc_out_queue import bmc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  res_t    push_data,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_data,
  output q_stat_t stat
);

  localparam logic [1:0] LAST = 2'(Q_DEPTH - 1);

  res_t       mem_r [Q_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid  = (count_r != 2'd0);
  assign pop        = out_valid && out_ready;
  assign out_data   = mem_r[rd_ptr_r];
  assign stat.count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? 2'd0 : wr_ptr_r + 2'd1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? 2'd0 : rd_ptr_r + 2'd1;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_button_mode_controller.sv -----
// Self-checking testbench for button_mode_controller: streams button/tick transactions,
// predicts every result in a local mode model and compares field by field.
// Depends on bmc_pkg and the button_mode_controller RTL only.
module tb_button_mode_controller import bmc_pkg::*; ;

  // Index with no register behind it; writes there must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned BTN_RED = 0;
  localparam int unsigned BTN_GREEN = 1;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned LONG_PRESS_ITEMS = 200;

  typedef enum {SEQ_RED, SEQ_GREEN, SEQ_BOTH, SEQ_NOISE, SEQ_QUIET} seq_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [0] red_pressed, [1] green_pressed, [2] second_tick
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [2:0] mode_now, [3] mode_changed, [4] acquire,
                                   // [12:5] led_red, [20:13] led_green, [28:21] led_blue
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  button_mode_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #24_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Mode model: shadow registers and state, advanced once per accepted transaction
  // ---------------------------------------------------------------------------
  logic [15:0] hold_lim, log_int, cfg_tmo;
  logic [2:0]  cur_mode, prev_mode;
  logic [15:0] hold_cnt [2];
  logic        hold_trk [2];
  logic        hold_done [2];
  logic [15:0] cfg_secs;
  logic [16:0] log_secs;
  logic        ret_pend, acq_pend;
  logic        mode_set;

  res_t results_due [$];   // predicted results, oldest first
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  function automatic void reset_model();
    hold_lim  = HOLD_MS_RST;
    log_int   = LOG_INTERVAL_RST;
    cfg_tmo   = CONFIG_TIMEOUT_RST;
    cur_mode  = MD_OFF;
    prev_mode = MD_STD;
    for (int b = 0; b < 2; b++) begin
      hold_cnt[b]  = 16'd0;
      hold_trk[b]  = 1'b0;
      hold_done[b] = 1'b0;
    end
    cfg_secs = 16'd0;
    log_secs = 17'd0;
    ret_pend = 1'b0;
    acq_pend = 1'b0;
  endfunction

  // Every mode set restarts both second counters; pending flags survive.
  function automatic void enter_mode(input logic [2:0] m);
    cur_mode = m;
    cfg_secs = 16'd0;
    log_secs = 17'd0;
    mode_set = 1'b1;
  endfunction

  // Long-press detector: count starts at 0 on the first pressed item, saturates,
  // fires once per press when it exceeds hold_lim.
  function automatic logic long_press(input int unsigned b, input logic level);
    if (!level) begin
      hold_cnt[b]  = 16'd0;
      hold_trk[b]  = 1'b0;
      hold_done[b] = 1'b0;
      return 1'b0;
    end
    if (!hold_trk[b]) begin
      hold_trk[b] = 1'b1;
      hold_cnt[b] = 16'd0;
    end else if (hold_cnt[b] != HOLD_MAX) begin
      hold_cnt[b] = hold_cnt[b] + 16'd1;
    end
    if (!hold_done[b] && hold_cnt[b] > hold_lim) begin
      hold_done[b] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [23:0] led_color(input logic [2:0] m);
    // {red, green, blue}
    case (m)
      MD_STD:   return {8'd0, 8'd255, 8'd0};
      MD_CFG:   return {8'd255, 8'd255, 8'd0};
      MD_MAINT: return {8'd255, 8'd80, 8'd0};
      MD_ECO:   return {8'd0, 8'd0, 8'd255};
      default:  return 24'd0;
    endcase
  endfunction

  function automatic res_t advance_modes(input logic red, input logic green, input logic tick);
    res_t r;
    logic [16:0] tick_limit;
    logic taken;
    logic [23:0] rgb;
    mode_set = 1'b0;
    taken = 1'b0;
    // second tick first; nothing counts in off mode
    if (tick && cur_mode != MD_OFF) begin
      if (cur_mode == MD_CFG) begin
        cfg_secs = cfg_secs + 16'd1;
        if (cfg_secs >= cfg_tmo) begin
          cfg_secs = 16'd0;
          ret_pend = 1'b1;
        end
      end else begin
        // eco doubles the interval, and so does maintenance entered from eco
        if (cur_mode == MD_ECO || (cur_mode == MD_MAINT && prev_mode == MD_ECO))
          tick_limit = {log_int, 1'b0};
        else
          tick_limit = {1'b0, log_int};
        log_secs = log_secs + 17'd1;
        if (log_secs >= tick_limit) begin
          log_secs = 17'd0;
          acq_pend = 1'b1;
        end
      end
    end
    if (long_press(BTN_RED, red)) begin
      if (cur_mode == MD_MAINT) begin
        enter_mode(prev_mode);
      end else begin
        prev_mode = cur_mode;
        enter_mode(MD_MAINT);
      end
    end
    if (long_press(BTN_GREEN, green)) begin
      if (cur_mode == MD_ECO)
        enter_mode(MD_STD);
      else if (cur_mode == MD_STD)
        enter_mode(MD_ECO);
    end
    if (cur_mode == MD_OFF) begin
      // leaving off skips the rest of the item; red wins over green
      if (red)
        enter_mode(MD_CFG);
      else if (green)
        enter_mode(MD_STD);
    end else begin
      if (cur_mode == MD_CFG && ret_pend) begin
        ret_pend = 1'b0;
        enter_mode(MD_STD);
      end
      if (acq_pend && cur_mode != MD_CFG) begin
        acq_pend = 1'b0;
        taken = 1'b1;
      end
    end
    rgb = led_color(cur_mode);
    r.mode_now     = cur_mode;
    r.mode_changed = mode_set;
    r.acquire      = taken;
    r.led_red      = rgb[23:16];
    r.led_green    = rgb[15:8];
    r.led_blue     = rgb[7:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  event        holdoff_go;
  logic        rx_hold = 1'b0;
  logic        rx_stall_en = 1'b0;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0]  rx_slot = 4'd0;

  initial begin
    forever begin
      @(holdoff_go);
      rx_hold <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rx_slot <= rx_slot + 4'd1;
    // new pattern each time rx_slot wraps; OR of two draws biases toward ready
    if (rx_slot == 4'd15)
      rx_pattern <= ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom | $urandom);
    out_tready <= !rx_hold && (!rx_stall_en || rx_pattern[rx_slot]);
  end

  // ---------------------------------------------------------------------------
  // Result checker: each result transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void report_field(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[28:0]);
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected transaction, data %h", results_seen, out_tdata);
      end else begin
        want = results_due.pop_front();
        report_field("mode_now", want.mode_now, got.mode_now);
        report_field("mode_changed", want.mode_changed, got.mode_changed);
        report_field("acquire", want.acquire, got.acquire);
        report_field("led_red", want.led_red, got.led_red);
        report_field("led_green", want.led_green, got.led_green);
        report_field("led_blue", want.led_blue, got.led_blue);
        report_field("tdata padding", 0, out_tdata[31:29]);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------------
  logic        tx_gaps_en = 1'b0;
  int unsigned tx_burst_left = 0;
  int unsigned tick_pct = 30;

  // Bursts of random length; a random gap may open before each burst.
  task automatic send_item(input logic red, input logic green, input logic tick);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      if (tx_gaps_en) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    tx_burst_left--;
    in_tdata  <= {5'd0, tick, green, red};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    results_due.push_back(advance_modes(red, green, tick));
  endtask

  function automatic logic tick_roll();
    return $urandom_range(0, 99) < tick_pct;
  endfunction

  // Drop valid, wait for every prediction to be matched, then cover the latency.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_HOLD_MS:        hold_lim = value;
      REG_LOG_INTERVAL:   log_int = value;
      REG_CONFIG_TIMEOUT: cfg_tmo = value;
      default: ;          // unmapped index: ignored
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] hold, input logic [15:0] interval,
                                input logic [15:0] timeout);
    settle();
    write_reg(REG_HOLD_MS, hold);
    write_reg(REG_LOG_INTERVAL, interval);
    write_reg(REG_CONFIG_TIMEOUT, timeout);
  endtask

  task automatic press(input logic red, input logic green, input int unsigned n);
    repeat (n) send_item(red, green, tick_roll());
  endtask

  // Mostly well-formed presses (some shorter, some longer than the hold time),
  // most followed by a release, with noise and quiet stretches mixed in.
  task automatic play_sequences(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned cap;
    int unsigned pick;
    seq_kind_t kind;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      kind = SEQ_RED;
      else if (pick < 65) kind = SEQ_GREEN;
      else if (pick < 75) kind = SEQ_BOTH;
      else if (pick < 88) kind = SEQ_NOISE;
      else                kind = SEQ_QUIET;
      cap = (hold_lim > 16'd30) ? 34 : int'(hold_lim) + 4;
      len = $urandom_range(1, cap);
      case (kind)
        SEQ_RED:   press(1'b1, 1'b0, len);
        SEQ_GREEN: press(1'b0, 1'b1, len);
        SEQ_BOTH:  press(1'b1, 1'b1, len);
        SEQ_NOISE: begin
          repeat (len) send_item(1'($urandom), 1'($urandom), 1'($urandom));
        end
        default:   press(1'b0, 1'b0, len);
      endcase
      sent += len;
      if ($urandom_range(0, 3) != 0) begin
        len = $urandom_range(1, 3);
        press(1'b0, 1'b0, len);
        sent += len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Off exit with both buttons (red wins), config timeout, acquisitions in
  // standard/eco/maintenance-from-eco, long presses among standard, eco and maintenance.
  task automatic test_directed_walk();
    apply_settings(16'd1, 16'd1, 16'd1);
    tx_gaps_en  = 1'b0;
    rx_stall_en <= 1'b0;
    send_item(1'b0, 1'b0, 1'b1);   // tick in off: no effect
    send_item(1'b1, 1'b1, 1'b0);   // leave off into config
    send_item(1'b0, 1'b0, 1'b1);   // config timeout back to standard
    send_item(1'b0, 1'b0, 1'b1);   // standard acquisition
    repeat (3) send_item(1'b0, 1'b1, 1'b0);   // green long press: eco
    repeat (2) send_item(1'b0, 1'b0, 1'b1);   // doubled interval
    repeat (3) send_item(1'b1, 1'b0, 1'b0);   // red long press: maintenance from eco
    repeat (2) send_item(1'b0, 1'b0, 1'b1);   // still doubled
    repeat (3) send_item(1'b1, 1'b0, 1'b0);   // red long press: back to eco
    repeat (3) send_item(1'b0, 1'b1, 1'b0);   // green long press: standard
    repeat (3) send_item(1'b1, 1'b1, 1'b0);   // both: red fires first
  endtask

  // Zero hold fires on the second pressed item; zero interval/timeout fire every tick.
  task automatic test_zero_settings();
    apply_settings(16'd0, 16'd0, 16'd0);
    tx_gaps_en  = 1'b1;
    rx_stall_en <= 1'b1;
    tick_pct = 40;
    play_sequences(200);
  endtask

  task automatic test_random_modes(input logic gaps, input logic stalls);
    apply_settings(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(1, 5)));
    write_reg(REG_UNUSED, 16'($urandom));
    tx_gaps_en  = gaps;
    rx_stall_en <= stalls;
    tick_pct = $urandom_range(15, 60);
    play_sequences(200);
  endtask

  // Largest interval and timeout, smallest nonzero hold.
  task automatic test_high_settings();
    apply_settings(16'd1, 16'hFFFF, 16'hFFFF);
    tx_gaps_en  = 1'b1;
    rx_stall_en <= 1'b1;
    tick_pct = 50;
    play_sequences(200);
  endtask

  // Receiver holds off for a long stretch while items keep coming; the result
  // queue fills and in_tready must drop.
  task automatic test_backpressure();
    apply_settings(16'd3, 16'd2, 16'd2);
    tx_gaps_en  = 1'b0;
    rx_stall_en <= 1'b0;
    tick_pct = 30;
    -> holdoff_go;
    play_sequences(250);
  endtask

  // Both buttons held a long stretch with the largest hold time: never fires.
  task automatic test_hold_max();
    apply_settings(HOLD_MAX, 16'd3, 16'd2);
    tx_gaps_en  = 1'b0;
    rx_stall_en <= 1'b0;
    tick_pct = 5;
    press(1'b1, 1'b1, LONG_PRESS_ITEMS);
    press(1'b0, 1'b0, 4);
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_walk();
    test_zero_settings();
    test_random_modes(1'b1, 1'b1);
    test_random_modes(1'b0, 1'b1);
    test_random_modes(1'b1, 1'b0);
    test_high_settings();
    test_backpressure();
    test_hold_max();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bmc_pkg.sv
hw/rtl/bmc_press_detect.sv
hw/rtl/bmc_mode_core.sv
hw/rtl/bmc_out_queue.sv
hw/rtl/button_mode_controller.sv
tb/sv/tb_button_mode_controller.sv
